@@ sv/piq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package piq_pkg;

    // Command codes carried by each input transaction
    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_DUMP   = 2'd3
    } cmd_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REJECT,
        ST_EMPTY,
        ST_DUMP
    } state_t;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_APPEND,
        OP_INSERT,
        OP_REMOVE,
        OP_DUMP_START,
        OP_ROTATE
    } dp_op_t;

    // Kind of result loaded into the output register
    typedef enum logic [1:0] {
        OUT_DATA,
        OUT_REJECT,
        OUT_EMPTY
    } out_kind_t;

    // Controller to datapath
    typedef struct packed {
        dp_op_t    op;
        logic      load_out;
        out_kind_t kind;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic dump_last;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ sv/positional_insert_queue_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Append, insert and remove: applied on acceptance, next transaction accepted the cycle after.
// Full-queue reject or empty dump: result loaded into the output register from the reject or empty state, then idle.
// Dump: entries are loaded one per cycle from the head register in the dump state, while the output
//   is free; idle again after the last entry, as the queue rotates through its head.
// Output stalls hold the controller in place; a waiting result never blocks acceptance.
// rst_n asynchronously clears the fill count, controller state and output valid.
module positional_insert_queue_unit #(
    parameter int DEPTH     = 16,
    parameter int TAG_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [4:0]  position,
    input  wire logic [31:0] item_value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      item,
    output logic             last,
    output logic             empty_res,
    output logic             rejected
);
    import piq_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    piq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (dp_cmd),
        .stat      (dp_stat)
    );

    piq_dp #(
        .DEPTH     (DEPTH),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .position   (position),
        .item_value (item_value),
        .item       (item),
        .last       (last),
        .empty_res  (empty_res),
        .rejected   (rejected)
    );

endmodule

`default_nettype wire

@@ sv/piq_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module piq_dp #(
    parameter int DEPTH     = 16,
    parameter int TAG_WIDTH = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire piq_pkg::dp_cmd_t  cmd,
    output piq_pkg::dp_stat_t      stat,
    input  wire logic [4:0]        position,
    input  wire logic [31:0]       item_value,
    output logic [31:0]            item,
    output logic                   last,
    output logic                   empty_res,
    output logic                   rejected
);
    import piq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (CW > 5) ? CW : 5;

    logic [TAG_WIDTH-1:0] entries_reg [DEPTH];
    logic [TAG_WIDTH-1:0] up_src   [DEPTH];
    logic [TAG_WIDTH-1:0] down_src [DEPTH];
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [CW-1:0]        rem_reg;
    logic [CW-1:0]        rem_next;
    logic [TAG_WIDTH-1:0] tag;
    logic [4:0]           pos_m1;
    logic [KW-1:0]        pos_w;
    logic [KW-1:0]        cnt_w;
    logic [CW-1:0]        ins_k;
    logic [CW-1:0]        last_idx;
    logic [31:0]          item_reg;
    logic                 last_reg;
    logic                 empty_res_reg;
    logic                 rejected_reg;

    assign tag = TAG_WIDTH'(item_value);

    // Neighbor sources for shifting toward head (up) and toward tail (down)
    for (genvar i = 0; i < DEPTH; i++) begin : g_src
        if (i == DEPTH - 1) begin : g_up_wrap
            assign up_src[i] = entries_reg[0];
        end else begin : g_up
            assign up_src[i] = entries_reg[i+1];
        end
        if (i == 0) begin : g_down_head
            assign down_src[i] = tag;
        end else begin : g_down
            assign down_src[i] = entries_reg[i-1];
        end
    end

    // Insert index: append goes to the tail; position 0 or 1 is head, past the tail clamps to tail
    always_comb
    begin
        pos_m1 = (position <= 5'd1) ? 5'd0 : position - 5'd1;
        pos_w  = KW'(pos_m1);
        cnt_w  = KW'(count_reg);
        if (cmd.op == OP_APPEND || pos_w > cnt_w)
        begin
            ins_k = count_reg;
        end
        else
        begin
            ins_k = CW'(pos_w);
        end
    end

    assign last_idx = count_reg - CW'(1);

    // Entry storage: shift for insert/remove, rotate within count for dump
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            case (cmd.op)
                OP_APPEND, OP_INSERT:
                begin
                    if (CW'(i) > ins_k)
                    begin
                        entries_reg[i] <= down_src[i];
                    end
                    else if (CW'(i) == ins_k)
                    begin
                        entries_reg[i] <= tag;
                    end
                end
                OP_REMOVE:
                begin
                    entries_reg[i] <= up_src[i];
                end
                OP_ROTATE:
                begin
                    if (CW'(i) == last_idx)
                    begin
                        entries_reg[i] <= entries_reg[0];
                    end
                    else if (CW'(i) < last_idx)
                    begin
                        entries_reg[i] <= up_src[i];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Fill count and remaining dump count
    always_comb
    begin
        count_next = count_reg;
        rem_next   = rem_reg;
        case (cmd.op)
            OP_APPEND, OP_INSERT: count_next = count_reg + CW'(1);
            OP_REMOVE:            count_next = count_reg - CW'(1);
            OP_DUMP_START:        rem_next   = count_reg;
            OP_ROTATE:            rem_next   = rem_reg - CW'(1);
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            rem_reg   <= rem_next;
        end
    end

    assign stat.full      = (count_reg == CW'(DEPTH));
    assign stat.empty     = (count_reg == '0);
    assign stat.dump_last = (rem_reg == CW'(1));

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            case (cmd.kind)
                OUT_DATA:
                begin
                    item_reg      <= 32'(entries_reg[0]);
                    last_reg      <= stat.dump_last;
                    empty_res_reg <= 1'b0;
                    rejected_reg  <= 1'b0;
                end
                OUT_REJECT:
                begin
                    item_reg      <= '0;
                    last_reg      <= 1'b1;
                    empty_res_reg <= 1'b0;
                    rejected_reg  <= 1'b1;
                end
                default:
                begin
                    item_reg      <= '0;
                    last_reg      <= 1'b1;
                    empty_res_reg <= 1'b1;
                    rejected_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign item      = item_reg;
    assign last      = last_reg;
    assign empty_res = empty_res_reg;
    assign rejected  = rejected_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_APPEND || cmd.op == OP_INSERT) |-> !stat.full)
        else $error("insert into full queue");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_APPEND || cmd.op == OP_INSERT)
            |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow queue");

    a_rotate_live: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_ROTATE) |-> (rem_reg != '0 && rem_reg <= count_reg))
        else $error("dump step without remaining entries");

endmodule

`default_nettype wire

@@ sv/piq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module piq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        command,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output piq_pkg::dp_cmd_t       cmd,
    input  wire piq_pkg::dp_stat_t stat
);
    import piq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    // State register and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.op       = OP_NONE;
        cmd.load_out = 1'b0;
        cmd.kind     = OUT_DATA;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (cmd_t'(command))
                        CMD_APPEND, CMD_INSERT:
                        begin
                            if (stat.full)
                            begin
                                state_next = ST_REJECT;
                            end
                            else if (cmd_t'(command) == CMD_APPEND)
                            begin
                                cmd.op = OP_APPEND;
                            end
                            else
                            begin
                                cmd.op = OP_INSERT;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (!stat.empty)
                            begin
                                cmd.op = OP_REMOVE;
                            end
                        end
                        default:
                        begin
                            if (stat.empty)
                            begin
                                state_next = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.op     = OP_DUMP_START;
                                state_next = ST_DUMP;
                            end
                        end
                    endcase
                end
            end
            ST_REJECT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.kind     = OUT_REJECT;
                    state_next   = ST_IDLE;
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.kind     = OUT_EMPTY;
                    state_next   = ST_IDLE;
                end
            end
            ST_DUMP:
            begin
                if (out_free)
                begin
                    cmd.op       = OP_ROTATE;
                    cmd.load_out = 1'b1;
                    cmd.kind     = OUT_DATA;
                    if (stat.dump_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register occupancy
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire
